// ===== rtl/bli_pkg.sv =====
// shared types, codes and reset values for the battery level led indicator
package bli_pkg;

   // operating modes, values as reported on the result beat
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_CHARGE = 2'd1,
      MODE_PON    = 2'd2,
      MODE_LP     = 2'd3
   } mode_type;

   // command codes carried in req_tuser
   localparam logic [2:0] FUNC_TICK      = 3'd0;
   localparam logic [2:0] FUNC_START     = 3'd1;
   localparam logic [2:0] FUNC_STOP      = 3'd2;
   localparam logic [2:0] FUNC_CHARGE    = 3'd3;
   localparam logic [2:0] FUNC_BACKLIGHT = 3'd4;

   // backlight pin states
   localparam logic [1:0] BL_LOW  = 2'd0;
   localparam logic [1:0] BL_HIGH = 2'd1;
   localparam logic [1:0] BL_HIZ  = 2'd2;

   // backlight request codes
   localparam logic [1:0] BLREQ_HIZ  = 2'd0;
   localparam logic [1:0] BLREQ_HIGH = 2'd1;
   localparam logic [1:0] BLREQ_LOW  = 2'd2;

   // red led patterns
   localparam logic [2:0] RED_NONE = 3'b000;
   localparam logic [2:0] RED_ONE  = 3'b001;
   localparam logic [2:0] RED_TWO  = 3'b011;
   localparam logic [2:0] RED_ALL  = 3'b111;

   // chase phase codes
   localparam logic [1:0] CHASE_NONE = 2'd0;
   localparam logic [1:0] CHASE_LED1 = 2'd1;
   localparam logic [1:0] CHASE_LED2 = 2'd2;
   localparam logic [1:0] CHASE_LED3 = 2'd3;

   // register indexes
   localparam logic [1:0] REG_FULL  = 2'd0;
   localparam logic [1:0] REG_HIGH  = 2'd1;
   localparam logic [1:0] REG_LOW   = 2'd2;
   localparam logic [1:0] REG_BLINK = 2'd3;

   // register reset values
   localparam logic [6:0] FULL_RESET  = 7'd99;
   localparam logic [6:0] HIGH_RESET  = 7'd75;
   localparam logic [6:0] LOW_RESET   = 7'd25;
   localparam logic [7:0] BLINK_RESET = 8'd2;

   localparam logic [7:0] TICK_MAX = 8'hFF;

   typedef struct packed {
      logic [6:0] full_level;
      logic [6:0] high_level;
      logic [6:0] low_level;
      logic [7:0] blink_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] func;
      logic [6:0] battery_level;
      logic       usb_present;
      logic       device_on;
      logic [1:0] backlight_request;
   } item_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] tick_count;
      logic       blink_phase;
      logic [1:0] chase_phase;
      logic [6:0] last_level;
      logic [2:0] red_pins;
      logic       blue_pin;
      logic [1:0] backlight;
   } state_type;

endpackage

// ===== rtl/battery_level_led_indicator.sv =====
// top level: input register, state and config registers, result register
// a request beat is held in the input register, and its result then passes to the result register
// throughput: one beat per cycle while results are taken, the state update is a single pass of compare logic
// the input register accepts a new beat while a result waits, as long as one slot is free
// reset (synchronous, active high) idles the mode, clears counters, filter and pins
// and loads the threshold registers with 99, 75, 25 and a blink period of 2 ticks
module battery_level_led_indicator import bli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] battery_level, [7] usb_present, [8] device_on, [10:9] backlight_request
   input  logic [15:0] req_tdata,
   // [2:0] func
   input  logic [2:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] red_lit, [3] blue_lit, [5:4] backlight_pin, [7:6] led_mode,
   // [14:8] filtered_level
   output logic [15:0] rsp_tdata,
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   item_type  item_ff;
   logic      item_valid_ff;
   logic      rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;
   logic      advance;

   // pipeline handshake
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_level  <= FULL_RESET;
         cfg_ff.high_level  <= HIGH_RESET;
         cfg_ff.low_level   <= LOW_RESET;
         cfg_ff.blink_ticks <= BLINK_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_FULL:  cfg_ff.full_level  <= csr_wdata[6:0];
            REG_HIGH:  cfg_ff.high_level  <= csr_wdata[6:0];
            REG_LOW:   cfg_ff.low_level   <= csr_wdata[6:0];
            REG_BLINK: cfg_ff.blink_ticks <= csr_wdata;
            default:   cfg_ff.blink_ticks <= cfg_ff.blink_ticks;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.func              <= req_tuser;
         item_ff.battery_level     <= req_tdata[6:0];
         item_ff.usb_present       <= req_tdata[7];
         item_ff.device_on         <= req_tdata[8];
         item_ff.backlight_request <= req_tdata[10:9];
      end
   end

   // step logic
   bli_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .next_state (state_in)
   );

   // indicator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_IDLE;
         state_ff.tick_count  <= 8'd0;
         state_ff.blink_phase <= 1'b0;
         state_ff.chase_phase <= CHASE_NONE;
         state_ff.last_level  <= 7'd0;
         state_ff.red_pins    <= RED_NONE;
         state_ff.blue_pin    <= 1'b0;
         state_ff.backlight   <= BL_LOW;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result beat packing
   assign rsp_data_in = {1'b0, state_in.last_level, state_in.mode, state_in.backlight,
                         state_in.blue_pin, state_in.red_pins};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/bli_step.sv =====
// next-state logic for one tick or command beat
module bli_step import bli_pkg::*; (
   input  state_type state,
   input  cfg_type   cfg,
   input  item_type  item,
   output state_type next_state
);

   logic [6:0] seed_level;
   logic [6:0] level;
   logic [7:0] tick_inc;
   logic       step_due;

   // monotonic level filter, a stored zero takes the raw reading
   assign seed_level = (state.last_level == 7'd0) ? item.battery_level : state.last_level;
   always_comb begin
      if (item.usb_present) begin
         level = (seed_level > item.battery_level) ? seed_level : item.battery_level;
      end else begin
         level = (seed_level < item.battery_level) ? seed_level : item.battery_level;
      end
   end

   // saturating tick counter and step check
   assign tick_inc = (state.tick_count == TICK_MAX) ? state.tick_count
                                                    : state.tick_count + 8'd1;
   assign step_due = (tick_inc >= cfg.blink_ticks);

   always_comb begin
      next_state = state;
      case (item.func)
         FUNC_TICK: begin
            next_state.last_level = level;
            case (state.mode)
               MODE_CHARGE: begin
                  next_state.tick_count = tick_inc;
                  if (level < cfg.full_level) begin
                     if (step_due) begin
                        next_state.tick_count = 8'd0;
                        case (state.chase_phase)
                           CHASE_LED1: begin
                              next_state.chase_phase = CHASE_LED2;
                              next_state.red_pins    = RED_ONE;
                           end
                           CHASE_LED2: begin
                              next_state.chase_phase = CHASE_LED3;
                              next_state.red_pins    = RED_TWO;
                           end
                           CHASE_LED3: begin
                              next_state.chase_phase = CHASE_LED1;
                              next_state.red_pins    = RED_ALL;
                           end
                           default: begin
                              next_state.chase_phase = CHASE_LED2;
                              next_state.red_pins    = RED_ONE;
                           end
                        endcase
                     end
                  end else begin
                     next_state.red_pins = RED_NONE;
                     next_state.blue_pin = 1'b1;
                  end
               end
               MODE_PON: begin
                  if (item.device_on) begin
                     if (level >= cfg.full_level) begin
                        next_state.red_pins = RED_ALL;
                     end else if (level >= cfg.high_level) begin
                        next_state.red_pins = RED_TWO;
                     end else if (level > cfg.low_level) begin
                        next_state.red_pins = RED_ONE;
                     end else begin
                        next_state.mode = MODE_LP;
                     end
                  end
               end
               MODE_LP: begin
                  next_state.tick_count = tick_inc;
                  if (step_due) begin
                     next_state.tick_count  = 8'd0;
                     next_state.blink_phase = ~state.blink_phase;
                     next_state.red_pins    = state.blink_phase ? RED_ONE : RED_NONE;
                  end
                  // recovered level returns to the level display
                  if (level > cfg.low_level) begin
                     next_state.mode       = MODE_PON;
                     next_state.tick_count = 8'd0;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_START: begin
            next_state.backlight = BL_LOW;
            next_state.mode      = MODE_PON;
         end
         FUNC_STOP: begin
            next_state.blue_pin  = 1'b0;
            next_state.red_pins  = RED_NONE;
            next_state.backlight = BL_LOW;
            next_state.mode      = MODE_IDLE;
         end
         FUNC_CHARGE: begin
            next_state.mode = MODE_CHARGE;
         end
         FUNC_BACKLIGHT: begin
            case (item.backlight_request)
               BLREQ_HIZ:  next_state.backlight = BL_HIZ;
               BLREQ_HIGH: next_state.backlight = BL_HIGH;
               BLREQ_LOW:  next_state.backlight = BL_LOW;
               default:    next_state.backlight = state.backlight;
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule
